>>> design/rc_channel_frame_generator_failsafe_core_macros.svh
// assertion macros for the rc channel frame generator
// used by the checker bound to the top level; expects clk_i and rst_ni in scope
`ifndef RC_CHANNEL_FRAME_GENERATOR_FAILSAFE_CORE_MACROS_SVH
`define RC_CHANNEL_FRAME_GENERATOR_FAILSAFE_CORE_MACROS_SVH

// same-cycle implication
`define RCFG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcfg check failed");

// next-cycle implication
`define RCFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcfg check failed");

`endif

>>> design/rcfg_pkg.sv
// shared types, constants and helper functions of the rc channel frame generator
// no dependencies
`default_nettype none

package rcfg_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int CH_IDX_W      = $clog2(CHANNEL_COUNT);
  localparam int CH_W          = 11;
  localparam int SV_W          = 20;
  localparam int SS_W          = 8;
  localparam int FRAME_LEN     = 26;
  localparam int BYTE_CNT_W    = 5;

  localparam logic [BYTE_CNT_W-1:0] HDR_LEN   = BYTE_CNT_W'(3);
  localparam logic [BYTE_CNT_W-1:0] CRC_START = BYTE_CNT_W'(2);
  localparam logic [BYTE_CNT_W-1:0] CRC_POS   = BYTE_CNT_W'(FRAME_LEN - 1);

  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam logic [7:0] SYNC_BYTE = 8'hC8;
  localparam logic [7:0] LEN_BYTE  = 8'h18;
  localparam logic [7:0] TYPE_BYTE = 8'h16;

  localparam logic [CH_W-1:0] CH_MIN  = 11'd172;
  localparam logic [CH_W-1:0] CH_MID  = 11'd992;
  localparam logic [CH_W-1:0] CH_HIGH = 11'd1792;

  localparam logic [CH_IDX_W-1:0] FS_CHANNEL = CH_IDX_W'(6);
  localparam logic [2:0]          STAB_LAST  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_LOCAL_TIMEOUT     = 3'd0;
  localparam logic [2:0] CFG_FAILSAFE_TIMEOUT  = 3'd1;
  localparam logic [2:0] CFG_STABILIZE_TIMEOUT = 3'd2;
  localparam logic [2:0] CFG_HOVER_VALUE       = 3'd3;
  localparam logic [2:0] CFG_FRAME_PERIOD      = 3'd4;

  // operation codes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  // link state codes
  localparam logic [1:0] LS_NORMAL    = 2'd0;
  localparam logic [1:0] LS_STABILIZE = 2'd1;
  localparam logic [1:0] LS_FAILSAFE  = 2'd2;
  localparam logic [1:0] LS_LOCAL     = 2'd3;

  typedef struct packed {
    logic [SV_W-1:0] local_to_ms;
    logic [SV_W-1:0] fs_to_ms;
    logic [SV_W-1:0] stab_to_ms;
    logic [CH_W-1:0] hover_level;
    logic [SS_W-1:0] frame_period;
  } rcfg_cfg_t;

  typedef struct packed {
    logic                en;
    logic [CH_IDX_W-1:0] addr;
    logic [CH_W-1:0]     data;
  } rcfg_wr_t;

  function automatic logic [CH_W-1:0] chan_init(input logic [CH_IDX_W-1:0] idx);
    logic [CH_W-1:0] v;
    case (idx)
      4'd0, 4'd1, 4'd3:               v = 11'd992;
      4'd2:                           v = 11'd1716;
      4'd4, 4'd5, 4'd6, 4'd7:         v = 11'd191;
      4'd8, 4'd9, 4'd10, 4'd11:       v = 11'd997;
      4'd12, 4'd13:                   v = 11'd0;
      default:                        v = 11'd1811;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = SYNC_BYTE;
      2'd1:    v = LEN_BYTE;
      default: v = TYPE_BYTE;
    endcase
    return v;
  endfunction

  // stabilize writes: channels 0, 1, 2, 3, 5
  function automatic logic [CH_IDX_W-1:0] stab_addr(input logic [2:0] step);
    logic [CH_IDX_W-1:0] a;
    case (step)
      3'd0:    a = CH_IDX_W'(0);
      3'd1:    a = CH_IDX_W'(1);
      3'd2:    a = CH_IDX_W'(2);
      3'd3:    a = CH_IDX_W'(3);
      default: a = CH_IDX_W'(5);
    endcase
    return a;
  endfunction

  function automatic logic [CH_W-1:0] stab_data(input logic [2:0] step,
                                                input logic [CH_W-1:0] hover);
    logic [CH_W-1:0] v;
    case (step)
      3'd2:             v = hover;
      3'd0, 3'd1, 3'd3: v = CH_MID;
      default:          v = CH_MIN;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/rc_channel_frame_generator_failsafe_core.sv
// top level of the rc channel frame generator with failsafe timeouts
// depends on rcfg_pkg, rcfg_cfg_regs and rcfg_chan_mem
`default_nettype none

// One item at a time. An update item writes channels 0 to 7 into the channel
// memory, one per cycle, and then gives one status item. A tick updates the
// millisecond counters and picks the timeout rule on acceptance, then writes
// the overridden channels (one channel for failsafe, five for stabilize) and
// gives either one status item or a 26-byte frame. With no receiver stall,
// header, 22 packed bytes and crc leave one a cycle, but for the merge steps:
// each of the 16 channel fetches from the channel memory takes a merge step of
// its own in the bit packer. A new item is taken as soon as the last result of
// the previous one sits in the output register. The channel memory needs no
// clearing pass after reset: per-entry valid bits return the power-up table for
// entries not yet written. Configuration is taken at any time through the plain
// write port and is meant to be written while idle.
module rc_channel_frame_generator_failsafe_core
  import rcfg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration write port
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [SV_W-1:0]  cfg_wdata_i,
  // input channel
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             operation_i,
  input  wire logic [CH_W-1:0]  chan_roll_i,
  input  wire logic [CH_W-1:0]  chan_pitch_i,
  input  wire logic [CH_W-1:0]  chan_throttle_i,
  input  wire logic [CH_W-1:0]  chan_yaw_i,
  input  wire logic [CH_W-1:0]  chan_aux_a_i,
  input  wire logic [CH_W-1:0]  chan_aux_b_i,
  input  wire logic [CH_W-1:0]  chan_aux_c_i,
  input  wire logic [CH_W-1:0]  chan_aux_d_i,
  input  wire logic             failsafe_mode_i,
  input  wire logic             remote_request_i,
  // output channel
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  kind_o,
  output logic [7:0]            frame_byte_o,
  output logic                  last_o,
  output logic                  switch_level_o,
  output logic [1:0]            link_state_o
);

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPD    = 5'b00010,
    ST_RULE   = 5'b00100,
    ST_FRAME  = 5'b01000,
    ST_STATUS = 5'b10000
  } rcfg_state_e;

  localparam logic [SV_W-1:0] SV_MAX = '1;
  localparam logic [SS_W-1:0] SS_MAX = '1;
  localparam int              ACC_W  = CH_W + 7;

  rcfg_cfg_t       cfg;
  rcfg_wr_t        mem_wr;
  logic [CH_W-1:0] chan_rd;

  rcfg_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;

  // update payload, written to memory channel by channel in ST_UPD
  logic [CH_W-1:0] upd_ch_q [8];
  logic [CH_W-1:0] upd_ch_d [8];

  logic            fs_flag_q, fs_flag_d;
  logic            last_remote_q, last_remote_d;
  logic            switch_q, switch_d;
  logic [SV_W-1:0] since_valid_q, since_valid_d;
  logic [SS_W-1:0] since_sent_q, since_sent_d;
  logic [1:0]      lstate_q, lstate_d;
  logic            frame_q, frame_d;

  // frame builder
  logic [BYTE_CNT_W-1:0] byte_cnt_q, byte_cnt_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [4:0]            nbits_q, nbits_d;
  logic [CH_IDX_W-1:0]   ch_idx_q, ch_idx_d;
  logic                  data_ok_q, data_ok_d;
  logic [7:0]            crc_q, crc_d;

  // output register
  logic       out_valid_q;
  logic       out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_switch_q;
  logic [1:0] out_lstate_q;

  logic       out_load;
  logic       out_kind_d;
  logic [7:0] out_byte_d;
  logic       out_last_d;
  logic       slot_free;

  rcfg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // the packer reads at ch_idx_q every cycle; data_ok_q marks a fresh read
  rcfg_chan_mem u_chan_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (mem_wr),
    .raddr_i (ch_idx_q),
    .rdata_o (chan_rd)
  );

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    logic [SV_W-1:0]  sv_inc;
    logic [SS_W-1:0]  ss_inc;
    logic             frame_go;
    logic [1:0]       rule;
    logic [ACC_W-1:0] shifted;

    state_d       = state_q;
    cnt_d         = cnt_q;
    upd_ch_d      = upd_ch_q;
    fs_flag_d     = fs_flag_q;
    last_remote_d = last_remote_q;
    switch_d      = switch_q;
    since_valid_d = since_valid_q;
    since_sent_d  = since_sent_q;
    lstate_d      = lstate_q;
    frame_d       = frame_q;
    byte_cnt_d    = byte_cnt_q;
    acc_d         = acc_q;
    nbits_d       = nbits_q;
    ch_idx_d      = ch_idx_q;
    data_ok_d     = 1'b1;
    crc_d         = crc_q;
    mem_wr        = '0;
    out_load      = 1'b0;
    out_kind_d    = KIND_STATUS;
    out_byte_d    = 8'h00;
    out_last_d    = 1'b1;

    // saturating millisecond counters
    sv_inc   = (since_valid_q == SV_MAX) ? since_valid_q : since_valid_q + SV_W'(1);
    ss_inc   = (since_sent_q == SS_MAX) ? since_sent_q : since_sent_q + SS_W'(1);
    frame_go = (ss_inc > cfg.frame_period);

    // timeout rules in priority order: local, failsafe, stabilize
    if (sv_inc >= cfg.local_to_ms) begin
      rule = LS_LOCAL;
    end else if (sv_inc >= cfg.fs_to_ms) begin
      rule = LS_FAILSAFE;
    end else if (sv_inc >= cfg.stab_to_ms) begin
      rule = LS_STABILIZE;
    end else begin
      rule = LS_NORMAL;
    end

    shifted = ACC_W'(chan_rd) << nbits_q[2:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d      = '0;
          byte_cnt_d = '0;
          acc_d      = '0;
          nbits_d    = '0;
          ch_idx_d   = '0;
          data_ok_d  = 1'b0;
          crc_d      = 8'h00;
          if (operation_i == OP_UPDATE) begin
            upd_ch_d[0]   = chan_roll_i;
            upd_ch_d[1]   = chan_pitch_i;
            upd_ch_d[2]   = chan_throttle_i;
            upd_ch_d[3]   = chan_yaw_i;
            upd_ch_d[4]   = chan_aux_a_i;
            upd_ch_d[5]   = chan_aux_b_i;
            upd_ch_d[6]   = chan_aux_c_i;
            upd_ch_d[7]   = chan_aux_d_i;
            fs_flag_d     = failsafe_mode_i;
            since_valid_d = '0;
            // the switch follows the request only on a change
            if (remote_request_i != last_remote_q) begin
              switch_d      = remote_request_i;
              last_remote_d = remote_request_i;
            end
            lstate_d = LS_NORMAL;
            frame_d  = 1'b0;
            state_d  = ST_UPD;
          end else begin
            since_valid_d = sv_inc;
            since_sent_d  = frame_go ? '0 : ss_inc;
            frame_d       = frame_go;
            lstate_d      = rule;
            if (rule == LS_LOCAL) begin
              switch_d = 1'b0;
            end
            if (rule == LS_FAILSAFE || rule == LS_STABILIZE) begin
              state_d = ST_RULE;
            end else begin
              state_d = frame_go ? ST_FRAME : ST_STATUS;
            end
          end
        end
      end

      ST_UPD: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = {1'b0, cnt_q};
        mem_wr.data = upd_ch_q[cnt_q];
        data_ok_d   = 1'b0;
        cnt_d       = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = ST_STATUS;
        end
      end

      ST_RULE: begin
        mem_wr.en = 1'b1;
        data_ok_d = 1'b0;
        cnt_d     = cnt_q + 3'd1;
        if (lstate_q == LS_FAILSAFE) begin
          mem_wr.addr = FS_CHANNEL;
          mem_wr.data = fs_flag_q ? CH_HIGH : CH_MID;
          state_d     = frame_q ? ST_FRAME : ST_STATUS;
        end else begin
          mem_wr.addr = stab_addr(cnt_q);
          mem_wr.data = stab_data(cnt_q, cfg.hover_level);
          if (cnt_q == STAB_LAST) begin
            state_d = frame_q ? ST_FRAME : ST_STATUS;
          end
        end
      end

      ST_STATUS: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_FRAME: begin
        out_kind_d = KIND_BYTE;
        out_last_d = 1'b0;
        if (byte_cnt_q < HDR_LEN) begin
          // sync, length and type bytes; crc starts at the type byte
          if (slot_free) begin
            out_load   = 1'b1;
            out_byte_d = hdr_byte(byte_cnt_q[1:0]);
            byte_cnt_d = byte_cnt_q + BYTE_CNT_W'(1);
            if (byte_cnt_q == CRC_START) begin
              crc_d = crc8_step(crc_q, out_byte_d);
            end
          end
        end else if (byte_cnt_q < CRC_POS) begin
          if (nbits_q >= 5'd8) begin
            if (slot_free) begin
              out_load   = 1'b1;
              out_byte_d = acc_q[7:0];
              crc_d      = crc8_step(crc_q, acc_q[7:0]);
              acc_d      = acc_q >> 8;
              nbits_d    = nbits_q - 5'd8;
              byte_cnt_d = byte_cnt_q + BYTE_CNT_W'(1);
            end
          end else if (data_ok_q) begin
            // merge the next channel above the pending bits
            acc_d     = acc_q | shifted;
            nbits_d   = nbits_q + 5'(CH_W);
            ch_idx_d  = ch_idx_q + CH_IDX_W'(1);
            data_ok_d = 1'b0;
          end
        end else begin
          if (slot_free) begin
            out_load   = 1'b1;
            out_byte_d = crc_q;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      fs_flag_q     <= 1'b0;
      last_remote_q <= 1'b0;
      switch_q      <= 1'b0;
      since_valid_q <= '0;
      since_sent_q  <= '0;
      lstate_q      <= LS_NORMAL;
      frame_q       <= 1'b0;
      byte_cnt_q    <= '0;
      nbits_q       <= '0;
      ch_idx_q      <= '0;
      data_ok_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      fs_flag_q     <= fs_flag_d;
      last_remote_q <= last_remote_d;
      switch_q      <= switch_d;
      since_valid_q <= since_valid_d;
      since_sent_q  <= since_sent_d;
      lstate_q      <= lstate_d;
      frame_q       <= frame_d;
      byte_cnt_q    <= byte_cnt_d;
      nbits_q       <= nbits_d;
      ch_idx_q      <= ch_idx_d;
      data_ok_q     <= data_ok_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    upd_ch_q <= upd_ch_d;
    acc_q    <= acc_d;
    crc_q    <= crc_d;
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_byte_q   <= out_byte_d;
      out_last_q   <= out_last_d;
      out_switch_q <= switch_q;
      out_lstate_q <= lstate_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign frame_byte_o   = out_byte_q;
  assign last_o         = out_last_q;
  assign switch_level_o = out_switch_q;
  assign link_state_o   = out_lstate_q;

endmodule

`default_nettype wire

>>> design/rcfg_cfg_regs.sv
// configuration register bank of the rc channel frame generator
// depends on rcfg_pkg
`default_nettype none

module rcfg_cfg_regs
  import rcfg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [SV_W-1:0]  cfg_wdata_i,
  output rcfg_cfg_t             cfg_o
);

  rcfg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOCAL_TIMEOUT:     cfg_d.local_to_ms  = cfg_wdata_i;
        CFG_FAILSAFE_TIMEOUT:  cfg_d.fs_to_ms     = cfg_wdata_i;
        CFG_STABILIZE_TIMEOUT: cfg_d.stab_to_ms   = cfg_wdata_i;
        CFG_HOVER_VALUE:       cfg_d.hover_level  = cfg_wdata_i[CH_W-1:0];
        CFG_FRAME_PERIOD:      cfg_d.frame_period = cfg_wdata_i[SS_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_to_ms  <= SV_W'(300000);
      cfg_q.fs_to_ms     <= SV_W'(5000);
      cfg_q.stab_to_ms   <= SV_W'(250);
      cfg_q.hover_level  <= CH_W'(1200);
      cfg_q.frame_period <= SS_W'(20);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/rcfg_chan_mem.sv
// channel store: 16 x 11 synchronous memory, one write and one registered read
// per-entry valid bits make unwritten entries read as the power-up table; uses rcfg_pkg
`default_nettype none

module rcfg_chan_mem
  import rcfg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rcfg_wr_t            wr_i,
  input  wire logic [CH_IDX_W-1:0] raddr_i,
  output logic      [CH_W-1:0]     rdata_o
);

  logic [CH_W-1:0]          mem_q [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] valid_q;
  logic [CH_W-1:0]          rdata_q;
  logic                     rvalid_q;
  logic [CH_IDX_W-1:0]      ridx_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
    ridx_q  <= raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : chan_init(ridx_q);

endmodule

`default_nettype wire

>>> design/rcfg_checker.sv
// port-level checker for the rc channel frame generator, bound to the top level
// depends on rcfg_pkg and the assertion macro header
`default_nettype none

`include "rc_channel_frame_generator_failsafe_core_macros.svh"

module rcfg_checker
  import rcfg_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       kind_o,
  input wire logic [7:0] frame_byte_o,
  input wire logic       last_o,
  input wire logic       switch_level_o,
  input wire logic [1:0] link_state_o
);

  // stalled result holds
  `RCFG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o) && $stable(frame_byte_o) && $stable(last_o))

  // a status item stands alone and carries no byte
  `RCFG_ASSERT_NOW(a_status_alone, out_valid_o && kind_o == KIND_STATUS, last_o && frame_byte_o == 8'h00)

  // no new item is taken in the middle of a frame
  `RCFG_ASSERT_NOW(a_frame_busy, out_valid_o && kind_o == KIND_BYTE && !last_o, !in_ready_o)

  // local timeout always leaves the switch on the local link
  `RCFG_ASSERT_NOW(a_local_switch, out_valid_o && link_state_o == LS_LOCAL, !switch_level_o)

endmodule

bind rc_channel_frame_generator_failsafe_core rcfg_checker u_rcfg_checker (.*);

`default_nettype wire

>>> dv/rcfg_frame_checker.sv
`timescale 1ns / 1ps
// result checker for the rc channel frame generator: watches both channels and the config port
// keeps its own copy of channel, counter and link state; depends on rcfg_pkg
module rcfg_frame_checker
  import rcfg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [SV_W-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             operation_i,
  input  logic [8*CH_W-1:0] chans_i,
  input  logic             failsafe_mode_i,
  input  logic             remote_request_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic             kind_i,
  input  logic [7:0]       frame_byte_i,
  input  logic             last_i,
  input  logic             switch_level_i,
  input  logic [1:0]       link_state_i,
  output int               results_pending_o,
  output int               mismatch_count_o
);

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       sw;
    logic [1:0] ls;
  } link_result_t;

  link_result_t    pending_results [$];
  int              mismatches;

  logic [SV_W-1:0] local_to, failsafe_to, stabilize_to;
  logic [CH_W-1:0] hover;
  logic [SS_W-1:0] frame_period;

  logic [CH_W-1:0] chan_model [CHANNEL_COUNT];
  logic            fs_model, last_remote, switch_model;
  logic [SV_W-1:0] since_update;
  logic [SS_W-1:0] since_frame;

  assign mismatch_count_o = mismatches;

  task automatic push_result(input logic kind, input logic [7:0] data, input logic last,
                             input logic [1:0] ls);
    link_result_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    r.sw   = switch_model;
    r.ls   = ls;
    pending_results.push_back(r);
  endtask

  // advances the model by one accepted item and queues what it should produce
  task automatic predict_link_item();
    logic [1:0]      ls;
    logic [175:0]    packed_chans;
    logic [7:0]      frame_bytes [FRAME_LEN];
    logic [7:0]      crc;
    logic            remote;
    ls = LS_NORMAL;
    if (operation_i == OP_UPDATE) begin
      for (int i = 0; i < 8; i++) chan_model[i] = chans_i[i*CH_W +: CH_W];
      fs_model     = failsafe_mode_i;
      remote       = remote_request_i;
      since_update = '0;
      if (remote != last_remote) begin
        switch_model = remote;
        last_remote  = remote;
      end
      push_result(KIND_STATUS, 8'd0, 1'b1, LS_NORMAL);
    end else begin
      if (since_update != {SV_W{1'b1}}) since_update++;
      if (since_frame != {SS_W{1'b1}}) since_frame++;
      if (since_update >= local_to) begin
        switch_model = 1'b0;
        ls = LS_LOCAL;
      end else if (since_update >= failsafe_to) begin
        chan_model[FS_CHANNEL] = fs_model ? CH_HIGH : CH_MID;
        ls = LS_FAILSAFE;
      end else if (since_update >= stabilize_to) begin
        chan_model[0] = CH_MID;
        chan_model[1] = CH_MID;
        chan_model[2] = hover;
        chan_model[3] = CH_MID;
        chan_model[5] = CH_MIN;
        ls = LS_STABILIZE;
      end
      if (since_frame > frame_period) begin
        for (int i = 0; i < CHANNEL_COUNT; i++) packed_chans[i*CH_W +: CH_W] = chan_model[i];
        frame_bytes[0] = SYNC_BYTE;
        frame_bytes[1] = LEN_BYTE;
        frame_bytes[2] = TYPE_BYTE;
        for (int k = 0; k < 22; k++) frame_bytes[3+k] = packed_chans[k*8 +: 8];
        crc = 8'd0;
        for (int k = 2; k < FRAME_LEN - 1; k++) begin
          crc = crc ^ frame_bytes[k];
          for (int b = 0; b < 8; b++) crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY)
                                                   : {crc[6:0], 1'b0};
        end
        frame_bytes[FRAME_LEN-1] = crc;
        since_frame = '0;
        for (int k = 0; k < FRAME_LEN; k++)
          push_result(KIND_BYTE, frame_bytes[k], k == FRAME_LEN - 1, ls);
      end else begin
        push_result(KIND_STATUS, 8'd0, 1'b1, ls);
      end
    end
  endtask

  task automatic check_result();
    link_result_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind %0d byte %0h", kind_i, frame_byte_i);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (kind_i !== want.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", want.kind, kind_i);
        mismatches++;
      end
      if (frame_byte_i !== want.data) begin
        $error("frame_byte mismatch: expected %0h, actual %0h", want.data, frame_byte_i);
        mismatches++;
      end
      if (last_i !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, last_i);
        mismatches++;
      end
      if (switch_level_i !== want.sw) begin
        $error("switch_level mismatch: expected %0d, actual %0d", want.sw, switch_level_i);
        mismatches++;
      end
      if (link_state_i !== want.ls) begin
        $error("link_state mismatch: expected %0d, actual %0d", want.ls, link_state_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_to     = 20'd300000;
      failsafe_to  = 20'd5000;
      stabilize_to = 20'd250;
      hover        = 11'd1200;
      frame_period = 8'd20;
      chan_model   = '{11'd992, 11'd992, 11'd1716, 11'd992, 11'd191, 11'd191, 11'd191,
                       11'd191, 11'd997, 11'd997, 11'd997, 11'd997, 11'd0, 11'd0,
                       11'd1811, 11'd1811};
      fs_model     = 1'b0;
      last_remote  = 1'b0;
      switch_model = 1'b0;
      since_update = '0;
      since_frame  = '0;
      mismatches   = 0;
      pending_results.delete();
      results_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOCAL_TIMEOUT:     local_to     = cfg_wdata_i;
          CFG_FAILSAFE_TIMEOUT:  failsafe_to  = cfg_wdata_i;
          CFG_STABILIZE_TIMEOUT: stabilize_to = cfg_wdata_i;
          CFG_HOVER_VALUE:       hover        = cfg_wdata_i[CH_W-1:0];
          CFG_FRAME_PERIOD:      frame_period = cfg_wdata_i[SS_W-1:0];
          default: ;
        endcase
      end
      // results first, so an item taken in the same cycle cannot mask a stray result
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_link_item();
      results_pending_o <= pending_results.size();
    end
  end

endmodule

>>> dv/rc_channel_frame_generator_failsafe_core_test.sv
`timescale 1ns / 1ps
// top of the rc channel frame generator testbench: clock, reset, stimulus and verdict
// depends on rcfg_pkg, the core and rcfg_frame_checker
module rc_channel_frame_generator_failsafe_core_test;
  import rcfg_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_idx = CFG_LOCAL_TIMEOUT;
  logic [SV_W-1:0]   cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              operation = OP_TICK;
  logic [8*CH_W-1:0] chan_bus = '0;       // channel 0 in the low bits
  logic              failsafe_mode = 1'b0;
  logic              remote_request = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              kind;
  logic [7:0]        frame_byte;
  logic              last;
  logic              switch_level;
  logic [1:0]        link_state;
  int                results_pending;
  int                mismatch_count;

  bit idling_on = 1'b1;       // random gaps on the sender and stalls on the receiver
  bit hold_off_req = 1'b0;    // asks the receiver for one long hold-off

  always #6 clk_i = ~clk_i;

  rc_channel_frame_generator_failsafe_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (operation),
    .chan_roll_i     (chan_bus[0*CH_W +: CH_W]),
    .chan_pitch_i    (chan_bus[1*CH_W +: CH_W]),
    .chan_throttle_i (chan_bus[2*CH_W +: CH_W]),
    .chan_yaw_i      (chan_bus[3*CH_W +: CH_W]),
    .chan_aux_a_i    (chan_bus[4*CH_W +: CH_W]),
    .chan_aux_b_i    (chan_bus[5*CH_W +: CH_W]),
    .chan_aux_c_i    (chan_bus[6*CH_W +: CH_W]),
    .chan_aux_d_i    (chan_bus[7*CH_W +: CH_W]),
    .failsafe_mode_i (failsafe_mode),
    .remote_request_i(remote_request),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .frame_byte_o    (frame_byte),
    .last_o          (last),
    .switch_level_o  (switch_level),
    .link_state_o    (link_state)
  );

  rcfg_frame_checker frame_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .operation_i      (operation),
    .chans_i          (chan_bus),
    .failsafe_mode_i  (failsafe_mode),
    .remote_request_i (remote_request),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .kind_i           (kind),
    .frame_byte_i     (frame_byte),
    .last_i           (last),
    .switch_level_i   (switch_level),
    .link_state_i     (link_state),
    .results_pending_o(results_pending),
    .mismatch_count_o (mismatch_count)
  );

  // eight channel values, each an extreme or a random value
  function automatic logic [8*CH_W-1:0] random_channels();
    logic [8*CH_W-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 5))
        0:       v[i*CH_W +: CH_W] = '0;
        1:       v[i*CH_W +: CH_W] = '1;
        default: v[i*CH_W +: CH_W] = CH_W'($urandom_range(0, 2047));
      endcase
    end
    return v;
  endfunction

  // called at a rising edge; returns at the edge where the item is taken, valid still high
  task automatic offer_item(input logic op, input logic [8*CH_W-1:0] chans,
                            input logic fs, input logic remote);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    chan_bus       <= chans;
    failsafe_mode  <= fs;
    remote_request <= remote;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // ticks carry random payload too, the block ignores it there
  task automatic offer_tick();
    offer_item(OP_TICK, random_channels(), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  // drop valid and let every outstanding result drain before touching config
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all five registers back to back, only while idle
  task automatic load_config(input logic [SV_W-1:0] local_to, input logic [SV_W-1:0] fs_to,
                             input logic [SV_W-1:0] stab_to, input logic [CH_W-1:0] hover,
                             input logic [SS_W-1:0] period);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_LOCAL_TIMEOUT;
    cfg_wdata <= local_to;
    @(posedge clk_i);
    cfg_idx   <= CFG_FAILSAFE_TIMEOUT;
    cfg_wdata <= fs_to;
    @(posedge clk_i);
    cfg_idx   <= CFG_STABILIZE_TIMEOUT;
    cfg_wdata <= stab_to;
    @(posedge clk_i);
    cfg_idx   <= CFG_HOVER_VALUE;
    cfg_wdata <= SV_W'(hover);
    @(posedge clk_i);
    cfg_idx   <= CFG_FRAME_PERIOD;
    cfg_wdata <= SV_W'(period);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // mostly an update followed by a run of ticks, so the timeouts get reached;
  // the rest is loose items of either kind
  task automatic run_traffic(input int n_items);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        offer_item(OP_UPDATE, random_channels(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        run_len = $urandom_range(0, 30);
        repeat (run_len) offer_tick();
        sent += run_len + 1;
      end else begin
        offer_item(1'($urandom_range(0, 1)), random_channels(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // receiver: random stall bursts, one long hold-off on request, steady when idling is off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // power-up config: a plain tick and an update that leaves the switch local
    offer_tick();
    offer_item(OP_UPDATE, '0, 1'b0, 1'b0);
    wait_idle();

    // short timeouts, frame on every tick: walk through stabilize, failsafe, local
    load_config(20'd5, 20'd3, 20'd2, 11'd2047, 8'd0);
    offer_item(OP_UPDATE, '1, 1'b1, 1'b1);
    repeat (5) offer_tick();
    // same remote request after a local timeout must not bring the switch back
    offer_item(OP_UPDATE, random_channels(), 1'b0, 1'b1);
    offer_item(OP_UPDATE, '0, 1'b0, 1'b0);
    offer_item(OP_UPDATE, '1, 1'b1, 1'b1);
    offer_tick();
    wait_idle();

    // zero timeouts hold on every tick; frames never go out with the period at its top
    load_config(20'd0, 20'd0, 20'd0, 11'd0, 8'd255);
    offer_tick();
    offer_item(OP_UPDATE, random_channels(), 1'b0, 1'b0);
    wait_idle();
    load_config(20'hFFFFF, 20'd0, 20'd0, 11'd0, 8'd255);
    repeat (2) offer_tick();
    wait_idle();
    load_config(20'hFFFFF, 20'hFFFFF, 20'd0, 11'd0, 8'd1);
    repeat (3) offer_tick();
    wait_idle();

    // random phases with small timeouts so every rule comes round often
    load_config(20'd40, 20'd20, 20'd8, 11'($urandom_range(0, 2047)), 8'd3);
    run_traffic(25);
    wait_idle();

    // long hold-off at the receiver while frames keep coming, so the input stalls
    load_config(20'hFFFFF, 20'd12, 20'd5, 11'($urandom_range(0, 2047)), 8'd0);
    hold_off_req = 1'b1;
    repeat (10) offer_tick();
    run_traffic(20);
    wait_idle();

    load_config(20'd25, 20'hFFFFF, 20'hFFFFF, 11'($urandom_range(0, 2047)), 8'd7);
    run_traffic(15);
    wait_idle();

    // frame counter saturates with the period at its top, then one frame once lowered
    load_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 11'($urandom_range(0, 2047)), 8'd255);
    repeat (270) offer_tick();
    wait_idle();
    load_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 11'($urandom_range(0, 2047)), 8'd254);
    offer_tick();
    wait_idle();

    // last stretch at full rate, no gaps and no stalls
    idling_on = 1'b0;
    load_config(20'($urandom_range(0, 60)), 20'($urandom_range(0, 40)),
                20'($urandom_range(0, 20)), 11'($urandom_range(0, 2047)),
                8'($urandom_range(0, 10)));
    run_traffic(25);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
